FILE: design/sha_pkg.sv
// Shared types and constants for the SHA-256 hash core.
// Holds the channel structs, the sequencer state type and the round constant table.
// No dependencies.
package sha_pkg;

	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_word;
	} msg_t;

	typedef struct packed {
		logic [2:0]  digest_index;
		logic [31:0] digest_word;
		logic        digest_last;
	} dig_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD,
		ST_OUT
	} state_t;

	// Control from the sequencer to the compression engine.
	typedef struct packed {
		logic        push;
		logic [31:0] word;
		logic        start;
		logic        chain_rst;
	} comp_ctl_t;

	localparam logic [31:0] PAD_MARK = 32'h8000_0000;
	localparam logic [3:0]  LEN_HI_POS = 4'd14;
	localparam logic [3:0]  LAST_POS = 4'd15;
	localparam logic [5:0]  LAST_ROUND = 6'd63;
	localparam logic [2:0]  LAST_DIGEST = 3'd7;
	localparam logic [2:0]  FULL_BYTES = 3'd4;

	localparam logic [7:0][31:0] INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

FILE: design/sha_comp.sv
// SHA-256 compression engine: one round per cycle over a 16-word schedule window.
// Holds the block buffer, working variables and chaining hash. Uses sha_pkg.
module sha_comp
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  comp_ctl_t   ctl,
	input  logic [2:0]  rd_idx,
	output logic [31:0] rd_word,
	output logic        done
);

	logic [31:0]      w_q [16];
	logic [31:0]      v_q [8];
	logic [7:0][31:0] chain_q;
	logic             run_q;
	logic             fin_q;
	logic [5:0]       rnd_q;

	logic [31:0] big1, choose, t1, big0, major, sig0, sig1, w_next;

	always_comb begin
		big1   = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]};
		choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1     = v_q[7] + big1 + choose + round_k(rnd_q) + w_q[0];
		big0   = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]};
		major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		// The window head is consumed by this round; the word sixteen ahead joins the tail.
		sig0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
			^ (w_q[1] >> 3);
		sig1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		w_next = w_q[0] + sig0 + w_q[9] + sig1;
	end

	always_ff @(posedge clk) begin
		if (ctl.push || run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= ctl.push ? ctl.word : w_next;
		end
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= chain_q[i];
			end
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + big0 + major;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= INIT_HASH;
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
		end else begin
			fin_q <= run_q && (rnd_q == LAST_ROUND);
			if (ctl.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == LAST_ROUND) begin
					run_q <= 1'b0;
				end
			end
			if (ctl.chain_rst) begin
				chain_q <= INIT_HASH;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
		end
	end

	assign rd_word = chain_q[rd_idx];
	assign done    = fin_q;

endmodule

FILE: design/sha256_hash_core.sv
// SHA-256 hash core: takes one message word per cycle while msg_stall is low; sixteen
// words fill a block and the sixteenth holds the input off for its compression (64
// rounds and the chaining add). A final word adds padding words and one or two such
// compressions, then the eight digest words leave under dig_stall back-pressure.
// Asynchronous active-low reset loads the initial hash and clears length and position.
module sha256_hash_core
	import sha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic msg_valid,
	output logic msg_stall,
	input  msg_t msg,
	output logic dig_valid,
	input  logic dig_stall,
	output dig_t dig
);

	state_t      state_q, state_d;
	logic [3:0]  pos_q;
	logic [63:0] bits_q;
	logic        pad_q, mark_q, lenhi_q, final_q;
	logic [2:0]  oidx_q;
	dig_t        dig_q;
	logic        dig_valid_q;

	comp_ctl_t   ctl;
	logic        done;
	logic [31:0] chain_word;
	logic        acc, load_out;
	logic [2:0]  cnt;
	logic [31:0] keep, mark, in_word, pad_word;

	sha_comp u_comp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_idx  (oidx_q),
		.rd_word (chain_word),
		.done    (done)
	);

	assign msg_stall = (state_q != ST_IDLE);
	assign acc       = msg_valid && !msg_stall;

	// Final word: keep the valid bytes and place the marker byte after them if room is left.
	always_comb begin
		cnt = (msg.byte_count > FULL_BYTES) ? FULL_BYTES : msg.byte_count;
		unique case (cnt)
			3'd0:    begin keep = 32'h0000_0000; mark = 32'h8000_0000; end
			3'd1:    begin keep = 32'hff00_0000; mark = 32'h0080_0000; end
			3'd2:    begin keep = 32'hffff_0000; mark = 32'h0000_8000; end
			3'd3:    begin keep = 32'hffff_ff00; mark = 32'h0000_0080; end
			default: begin keep = 32'hffff_ffff; mark = 32'h0000_0000; end
		endcase
		in_word = msg.last_word ? ((msg.data_word & keep) | mark) : msg.data_word;
		priority if (mark_q) begin
			pad_word = PAD_MARK;
		end else if (lenhi_q) begin
			pad_word = bits_q[31:0];
		end else if (pos_q == LEN_HI_POS) begin
			pad_word = bits_q[63:32];
		end else begin
			pad_word = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (pos_q == LAST_POS) begin
						state_d = ST_COMP;
					end else if (msg.last_word) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				if (done) begin
					priority if (final_q) begin
						state_d = ST_OUT;
					end else if (pad_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_PAD: begin
				if (pos_q == LAST_POS) begin
					state_d = ST_COMP;
				end
			end
			ST_OUT: begin
				if (load_out && (oidx_q == LAST_DIGEST)) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.push = acc;
				ctl.word = in_word;
			end
			ST_PAD: begin
				ctl.push = 1'b1;
				ctl.word = pad_word;
			end
			ST_OUT: begin
				load_out      = !dig_valid_q || !dig_stall;
				ctl.chain_rst = load_out && (oidx_q == LAST_DIGEST);
			end
			default: begin
			end
		endcase
		ctl.start = ctl.push && (pos_q == LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			bits_q      <= '0;
			pad_q       <= 1'b0;
			mark_q      <= 1'b0;
			lenhi_q     <= 1'b0;
			final_q     <= 1'b0;
			oidx_q      <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				pos_q <= pos_q + 4'd1;
			end
			if (acc) begin
				bits_q <= bits_q + (msg.last_word ? {58'd0, cnt, 3'd0} : 64'd32);
				if (msg.last_word) begin
					pad_q  <= 1'b1;
					mark_q <= (cnt == FULL_BYTES);
				end
			end
			if (state_q == ST_PAD) begin
				priority if (mark_q) begin
					mark_q <= 1'b0;
				end else if (lenhi_q) begin
					final_q <= 1'b1;
				end else if (pos_q == LEN_HI_POS) begin
					lenhi_q <= 1'b1;
				end
			end
			if (load_out) begin
				oidx_q      <= oidx_q + 3'd1;
				dig_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				dig_valid_q <= 1'b0;
			end
			// The last digest transaction starts a fresh message.
			if (ctl.chain_rst) begin
				pos_q   <= '0;
				bits_q  <= '0;
				pad_q   <= 1'b0;
				lenhi_q <= 1'b0;
				final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dig_q.digest_index <= oidx_q;
			dig_q.digest_word  <= chain_word;
			dig_q.digest_last  <= (oidx_q == LAST_DIGEST);
		end
	end

	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

endmodule
